@@ hdl/stng_pkg.sv @@
package stng_pkg;

  // One input item: a register write byte or a sample tick.
  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } in_t;

  // One result item: four attenuation levels and the mixed amplitude.
  typedef struct packed {
    logic [3:0]  level_tone0;
    logic [3:0]  level_tone1;
    logic [3:0]  level_tone2;
    logic [3:0]  level_noise;
    logic [15:0] mixed_level;
  } out_t;

  // Input function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Channel number that selects the noise channel.
  localparam logic [1:0] NOISE_CHAN = 2'd3;

  // Noise rate select codes.
  localparam logic [1:0] RATE_16   = 2'd0;
  localparam logic [1:0] RATE_32   = 2'd1;
  localparam logic [1:0] RATE_64   = 2'd2;
  localparam logic [1:0] RATE_TONE = 2'd3;

  // Reset and reload values.
  localparam logic [15:0] LFSR_SEED     = 16'h0080;
  localparam logic [9:0]  NOISE_PER_RST = 10'h010;
  localparam logic [3:0]  ATTEN_SILENT  = 4'hF;

  // Commands passed from the decoder to the channel engine.
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_ATTEN,
    CMD_PERIOD_LO,
    CMD_PERIOD_HI,
    CMD_NOISE_MODE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [1:0] chan;
    logic [5:0] value;
  } cmd_t;

  // Attenuation to amplitude in Q0.15.
  function automatic logic [15:0] vol_q15(input logic [3:0] lvl);
    logic [15:0] v;
    case (lvl)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd6507;
      4'd2:    v = 16'd5169;
      4'd3:    v = 16'd4106;
      4'd4:    v = 16'd3261;
      4'd5:    v = 16'd2591;
      4'd6:    v = 16'd2058;
      4'd7:    v = 16'd1635;
      4'd8:    v = 16'd1298;
      4'd9:    v = 16'd1031;
      4'd10:   v = 16'd819;
      4'd11:   v = 16'd651;
      4'd12:   v = 16'd517;
      4'd13:   v = 16'd411;
      4'd14:   v = 16'd326;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/stng_front.sv @@
module stng_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  stng_pkg::in_t     in_data_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output stng_pkg::cmd_t    q_cmd_o
);

  logic [1:0] latch_channel_q, latch_channel_d;
  logic       latch_is_volume_q, latch_is_volume_d;
  logic       accept;
  logic       want_push;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept && want_push;

  // Classify the item and track the latched register.
  always_comb begin
    latch_channel_d   = latch_channel_q;
    latch_is_volume_d = latch_is_volume_q;
    want_push         = 1'b1;
    q_cmd_o.kind      = stng_pkg::CMD_TICK;
    q_cmd_o.chan      = latch_channel_q;
    q_cmd_o.value     = in_data_i.data[5:0];
    if (in_data_i.func == stng_pkg::FUNC_TICK) begin
      q_cmd_o.kind = stng_pkg::CMD_TICK;
    end else if (in_data_i.data[7]) begin
      latch_channel_d   = in_data_i.data[6:5];
      latch_is_volume_d = in_data_i.data[4];
      q_cmd_o.chan      = in_data_i.data[6:5];
      if (in_data_i.data[4]) begin
        q_cmd_o.kind = stng_pkg::CMD_ATTEN;
      end else if (in_data_i.data[6:5] == stng_pkg::NOISE_CHAN) begin
        q_cmd_o.kind = stng_pkg::CMD_NOISE_MODE;
      end else begin
        q_cmd_o.kind = stng_pkg::CMD_PERIOD_LO;
      end
    end else if (!latch_is_volume_q) begin
      if (latch_channel_q == stng_pkg::NOISE_CHAN) begin
        q_cmd_o.kind = stng_pkg::CMD_NOISE_MODE;
      end else begin
        q_cmd_o.kind = stng_pkg::CMD_PERIOD_HI;
      end
    end else begin
      // A data byte after a volume latch has no effect.
      want_push = 1'b0;
    end
  end

  // Latch state changes only on an accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_channel_q   <= 2'd0;
      latch_is_volume_q <= 1'b0;
    end else if (accept) begin
      latch_channel_q   <= latch_channel_d;
      latch_is_volume_q <= latch_is_volume_d;
    end
  end

endmodule

@@ hdl/stng_queue.sv @@
module stng_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stng_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           avail_o,
  output stng_pkg::cmd_t pop_cmd_o
);

  stng_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o    = (count_q == 2'd2);
  assign avail_o   = (count_q != 2'd0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_pop    = pop_i && avail_o;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ hdl/stng_back.sv @@
module stng_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_avail_i,
  input  stng_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stng_pkg::out_t out_data_o
);

  logic [9:0]  tone_period_q [3];
  logic [9:0]  tone_period_d [3];
  logic [9:0]  tone_count_q  [3];
  logic [9:0]  tone_count_d  [3];
  logic [2:0]  tone_phase_q, tone_phase_d;
  logic [3:0]  tone_atten_q  [3];
  logic [3:0]  tone_atten_d  [3];
  logic [1:0]  noise_rate_sel_q, noise_rate_sel_d;
  logic        noise_white_q, noise_white_d;
  logic [9:0]  noise_count_q, noise_count_d;
  logic [9:0]  noise_period_q, noise_period_d;
  logic [15:0] noise_lfsr_q, noise_lfsr_d;
  logic        noise_phase_q, noise_phase_d;
  logic [3:0]  noise_atten_q, noise_atten_d;

  logic           out_valid_q, out_valid_d;
  stng_pkg::out_t out_data_q, out_data_d;

  logic        is_tick;
  logic        out_free;
  logic [3:0]  tone_lvl [3];
  logic [3:0]  noise_lvl;

  assign is_tick     = (cmd_i.kind == stng_pkg::CMD_TICK);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cmd_pop_o   = cmd_avail_i && (!is_tick || out_free);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Tone channels: one sample of counter, phase and level.
  always_comb begin
    logic [9:0] dec;
    logic       fire;
    logic       slow;
    for (int c = 0; c < 3; c++) begin
      dec  = tone_count_q[c] - 10'd1;
      fire = (tone_count_q[c] == 10'd0) || (dec == 10'd0);
      slow = (tone_period_q[c] > 10'd1);
      tone_count_d[c] = fire ? tone_period_q[c] : dec;
      tone_phase_d[c] = tone_phase_q[c] ^ (fire && slow);
      if (!slow || tone_phase_d[c]) begin
        tone_lvl[c] = tone_atten_q[c];
      end else begin
        tone_lvl[c] = stng_pkg::ATTEN_SILENT;
      end
    end
  end

  // Noise channel: counter, phase, LFSR shift and period reload.
  logic [9:0]  n_dec;
  logic        n_fire;
  logic        n_clk;
  logic        n_fb;
  logic [15:0] n_lfsr_tick;
  logic        n_phase_tick;
  logic [9:0]  n_period_tick;
  logic [9:0]  n_count_tick;

  always_comb begin
    n_dec        = noise_count_q - 10'd1;
    n_fire       = (noise_count_q == 10'd0) || (n_dec == 10'd0);
    n_phase_tick = noise_phase_q;
    n_clk        = 1'b0;
    if (n_fire) begin
      if (noise_period_q > 10'd1) begin
        n_phase_tick = ~noise_phase_q;
        n_clk        = ~noise_phase_q;
      end else begin
        n_clk = ~noise_phase_q;
      end
    end
    n_fb = noise_white_q ? (noise_lfsr_q[15] ^ noise_lfsr_q[12]) : noise_lfsr_q[15];
    n_lfsr_tick = n_clk ? {noise_lfsr_q[14:0], n_fb} : noise_lfsr_q;
    case (noise_rate_sel_q)
      stng_pkg::RATE_16: n_period_tick = 10'h010;
      stng_pkg::RATE_32: n_period_tick = 10'h020;
      stng_pkg::RATE_64: n_period_tick = 10'h040;
      default:           n_period_tick = tone_period_q[2];
    endcase
    if (!n_fire) begin
      n_period_tick = noise_period_q;
    end
    n_count_tick = n_fire ? n_period_tick : n_dec;
    noise_lvl    = n_lfsr_tick[7] ? noise_atten_q : stng_pkg::ATTEN_SILENT;
  end

  // Next state: apply the popped command.
  always_comb begin
    tone_period_d    = tone_period_q;
    tone_atten_d     = tone_atten_q;
    noise_rate_sel_d = noise_rate_sel_q;
    noise_white_d    = noise_white_q;
    noise_count_d    = noise_count_q;
    noise_period_d   = noise_period_q;
    noise_lfsr_d     = noise_lfsr_q;
    noise_phase_d    = noise_phase_q;
    noise_atten_d    = noise_atten_q;
    unique case (cmd_i.kind)
      stng_pkg::CMD_TICK: begin
        noise_count_d  = n_count_tick;
        noise_period_d = n_period_tick;
        noise_lfsr_d   = n_lfsr_tick;
        noise_phase_d  = n_phase_tick;
      end
      stng_pkg::CMD_ATTEN: begin
        if (cmd_i.chan == stng_pkg::NOISE_CHAN) begin
          noise_atten_d = cmd_i.value[3:0];
        end
        for (int c = 0; c < 3; c++) begin
          if (cmd_i.chan == 2'(c)) begin
            tone_atten_d[c] = cmd_i.value[3:0];
          end
        end
      end
      stng_pkg::CMD_PERIOD_LO: begin
        for (int c = 0; c < 3; c++) begin
          if (cmd_i.chan == 2'(c)) begin
            tone_period_d[c] = {tone_period_q[c][9:4], cmd_i.value[3:0]};
          end
        end
      end
      stng_pkg::CMD_PERIOD_HI: begin
        for (int c = 0; c < 3; c++) begin
          if (cmd_i.chan == 2'(c)) begin
            tone_period_d[c] = {cmd_i.value, tone_period_q[c][3:0]};
          end
        end
      end
      stng_pkg::CMD_NOISE_MODE: begin
        noise_rate_sel_d = cmd_i.value[1:0];
        noise_white_d    = cmd_i.value[2];
        if (!cmd_i.value[2]) begin
          noise_lfsr_d = stng_pkg::LFSR_SEED;
        end
      end
      default: begin
        noise_atten_d = noise_atten_q;
      end
    endcase
  end

  // Result register: load on a tick, drain on a transfer.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (cmd_pop_o && is_tick) begin
      out_valid_d            = 1'b1;
      out_data_d.level_tone0 = tone_lvl[0];
      out_data_d.level_tone1 = tone_lvl[1];
      out_data_d.level_tone2 = tone_lvl[2];
      out_data_d.level_noise = noise_lvl;
      out_data_d.mixed_level = stng_pkg::vol_q15(tone_lvl[0]) + stng_pkg::vol_q15(tone_lvl[1])
                             + stng_pkg::vol_q15(tone_lvl[2]) + stng_pkg::vol_q15(noise_lvl);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        tone_period_q[c] <= 10'd0;
        tone_count_q[c]  <= 10'd0;
        tone_atten_q[c]  <= stng_pkg::ATTEN_SILENT;
      end
      tone_phase_q     <= 3'd0;
      noise_rate_sel_q <= stng_pkg::RATE_16;
      noise_white_q    <= 1'b0;
      noise_count_q    <= stng_pkg::NOISE_PER_RST;
      noise_period_q   <= stng_pkg::NOISE_PER_RST;
      noise_lfsr_q     <= stng_pkg::LFSR_SEED;
      noise_phase_q    <= 1'b0;
      noise_atten_q    <= stng_pkg::ATTEN_SILENT;
      out_valid_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_pop_o) begin
        tone_period_q    <= tone_period_d;
        tone_atten_q     <= tone_atten_d;
        noise_rate_sel_q <= noise_rate_sel_d;
        noise_white_q    <= noise_white_d;
        noise_count_q    <= noise_count_d;
        noise_period_q   <= noise_period_d;
        noise_lfsr_q     <= noise_lfsr_d;
        noise_phase_q    <= noise_phase_d;
        noise_atten_q    <= noise_atten_d;
        if (is_tick) begin
          tone_count_q <= tone_count_d;
          tone_phase_q <= tone_phase_d;
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

@@ hdl/square_tone_noise_generator.sv @@
// An accepted tick is written into the command queue and then popped into the registered result.
// Throughput: one item per cycle, writes and ticks alike, unless a stalled output holds back ticks;
// the two-entry command queue between the decoder and the channel engine sets the buffer depth.
// Register writes give no result. Reset (rst_ni low, asynchronous) silences all channels, clears
// tone periods and counters, sets the noise period and counter to 0x010, seeds the LFSR with 0x80.
module square_tone_noise_generator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  stng_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stng_pkg::out_t out_data_o
);

  logic           q_full;
  logic           q_push;
  stng_pkg::cmd_t q_push_cmd;
  logic           q_pop;
  logic           q_avail;
  stng_pkg::cmd_t q_pop_cmd;

  // Decoder and latch tracking.
  stng_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_push_cmd)
  );

  // Command queue.
  stng_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .avail_o    (q_avail),
    .pop_cmd_o  (q_pop_cmd)
  );

  // Channel engine and result register.
  stng_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_avail_i (q_avail),
    .cmd_i       (q_pop_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
